// ===== hw/rtl/mit_pkg.sv =====
// ----------------------------------------------------------------------------
// mit_pkg
// Shared types and constants of the 3x3 inverse-transpose pipeline.
// ----------------------------------------------------------------------------
package mit_pkg;

	localparam int unsigned NumEnt = 9;
	localparam int unsigned InW    = 16;
	localparam int unsigned OutW   = 32;
	localparam int unsigned LimW   = 40;
	localparam int unsigned CofW   = 33;
	localparam int unsigned DetW   = 51;
	// The Hadamard bound keeps the determinant magnitude below 2^48.
	localparam int unsigned DenW   = 48;
	localparam int unsigned NumW   = 60;
	localparam int unsigned QBits  = 33;
	localparam int unsigned CofLat = 4;

	localparam logic [LimW-1:0] LimitReset = 40'd68719;
	localparam logic [OutW-1:0] Q16One     = 32'h0001_0000;

	typedef logic signed [InW-1:0]  ent_t;
	typedef logic signed [CofW-1:0] cof_t;
	typedef logic signed [DetW-1:0] det_t;
	typedef logic [DenW-1:0]        den_t;
	typedef logic [NumW-1:0]        num_t;
	typedef logic [OutW-1:0]        res_t;
	typedef logic [LimW-1:0]        lim_t;

	// Each cofactor is m[A]*m[B] - m[C]*m[D], signs already folded in.
	localparam int unsigned CofA [NumEnt] = '{4, 5, 3, 2, 0, 1, 1, 2, 0};
	localparam int unsigned CofB [NumEnt] = '{8, 6, 7, 7, 8, 6, 5, 3, 4};
	localparam int unsigned CofC [NumEnt] = '{5, 3, 4, 1, 2, 0, 2, 0, 1};
	localparam int unsigned CofD [NumEnt] = '{7, 8, 6, 8, 6, 7, 4, 5, 3};

endpackage

// ===== hw/rtl/mit_if.sv =====
// ----------------------------------------------------------------------------
// mit_in_if / mit_out_if
// Valid/ready channels for matrix requests and result requests.
// ----------------------------------------------------------------------------
interface mit_in_if;
	logic valid;
	logic ready;
	logic signed [15:0] in_r0_c0;
	logic signed [15:0] in_r0_c1;
	logic signed [15:0] in_r0_c2;
	logic signed [15:0] in_r1_c0;
	logic signed [15:0] in_r1_c1;
	logic signed [15:0] in_r1_c2;
	logic signed [15:0] in_r2_c0;
	logic signed [15:0] in_r2_c1;
	logic signed [15:0] in_r2_c2;

	modport source (output valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1,
		in_r1_c2, in_r2_c0, in_r2_c1, in_r2_c2, input ready);
	modport sink (input valid, in_r0_c0, in_r0_c1, in_r0_c2, in_r1_c0, in_r1_c1,
		in_r1_c2, in_r2_c0, in_r2_c1, in_r2_c2, output ready);
endinterface

interface mit_out_if;
	logic valid;
	logic ready;
	logic signed [31:0] out_r0_c0;
	logic signed [31:0] out_r0_c1;
	logic signed [31:0] out_r0_c2;
	logic signed [31:0] out_r1_c0;
	logic signed [31:0] out_r1_c1;
	logic signed [31:0] out_r1_c2;
	logic signed [31:0] out_r2_c0;
	logic signed [31:0] out_r2_c1;
	logic signed [31:0] out_r2_c2;
	logic singular;

	modport source (output valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
		out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular, input ready);
	modport sink (input valid, out_r0_c0, out_r0_c1, out_r0_c2, out_r1_c0, out_r1_c1,
		out_r1_c2, out_r2_c0, out_r2_c1, out_r2_c2, singular, output ready);
endinterface

// ===== hw/rtl/mit_cofactor.sv =====
// ----------------------------------------------------------------------------
// mit_cofactor
// Four-stage pipeline forming the nine cofactors and the determinant.
// ----------------------------------------------------------------------------
module mit_cofactor (
	input  logic            clk,
	input  logic            en,
	input  mit_pkg::ent_t   m [mit_pkg::NumEnt],
	output mit_pkg::cof_t   cof [mit_pkg::NumEnt],
	output mit_pkg::det_t   det
);

	logic signed [31:0] pa_s1 [mit_pkg::NumEnt];
	logic signed [31:0] pb_s1 [mit_pkg::NumEnt];
	mit_pkg::ent_t      row_s1 [3];
	mit_pkg::ent_t      row_s2 [3];
	mit_pkg::cof_t      cof_s2 [mit_pkg::NumEnt];
	mit_pkg::cof_t      cof_s3 [mit_pkg::NumEnt];
	mit_pkg::cof_t      cof_s4 [mit_pkg::NumEnt];
	logic signed [48:0] dp_s3 [3];
	mit_pkg::det_t      det_s4;

	for (genvar k = 0; k < mit_pkg::NumEnt; k++) begin : g_ent
		always_ff @(posedge clk) begin
			if (en) begin
				pa_s1[k]  <= m[mit_pkg::CofA[k]] * m[mit_pkg::CofB[k]];
				pb_s1[k]  <= m[mit_pkg::CofC[k]] * m[mit_pkg::CofD[k]];
				cof_s2[k] <= mit_pkg::cof_t'(pa_s1[k]) - mit_pkg::cof_t'(pb_s1[k]);
				cof_s3[k] <= cof_s2[k];
				cof_s4[k] <= cof_s3[k];
			end
		end
		assign cof[k] = cof_s4[k];
	end

	for (genvar j = 0; j < 3; j++) begin : g_row
		always_ff @(posedge clk) begin
			if (en) begin
				row_s1[j] <= m[j];
				row_s2[j] <= row_s1[j];
				dp_s3[j]  <= row_s2[j] * cof_s2[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s4 <= mit_pkg::det_t'(dp_s3[0]) + mit_pkg::det_t'(dp_s3[1])
				+ mit_pkg::det_t'(dp_s3[2]);
		end
	end

	assign det = det_s4;

endmodule

// ===== hw/rtl/mit_div_lane.sv =====
// ----------------------------------------------------------------------------
// mit_div_lane
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module mit_div_lane (
	input  logic           clk,
	input  logic           en,
	input  mit_pkg::num_t  num,
	input  mit_pkg::den_t  den,
	input  logic           neg,
	output mit_pkg::res_t  q
);

	localparam int unsigned QB = mit_pkg::QBits;
	localparam int unsigned DW = mit_pkg::DenW;

	logic [DW-1:0] rem_s [QB+1];
	logic [QB-1:0] low_s [QB+1];
	logic [QB-1:0] quo_s [QB+1];
	logic [DW-1:0] den_s [QB+1];
	logic          neg_s [QB+1];
	logic          ovf_s [QB+1];

	logic [DW-1:0] head;
	logic          ovf;

	assign head = DW'(num[mit_pkg::NumW-1:QB]);
	assign ovf  = head >= den;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= ovf ? '0 : head;
			low_s[0] <= num[QB-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf;
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;
		logic [QB-1:0] qn;

		always_comb begin
			trial = {rem_s[k-1], low_s[k-1][QB-k]};
			ge    = trial >= {1'b0, den_s[k-1]};
			qn    = quo_s[k-1];
			qn[QB-k] = ge;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(trial - {1'b0, den_s[k-1]}) : trial[DW-1:0];
				low_s[k] <= low_s[k-1];
				quo_s[k] <= qn;
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	always_comb begin
		if (neg_s[QB]) begin
			if (ovf_s[QB] || quo_s[QB] > QB'(33'h0_8000_0000)) begin
				q = 32'h8000_0000;
			end else begin
				q = mit_pkg::res_t'(-quo_s[QB]);
			end
		end else begin
			if (ovf_s[QB] || quo_s[QB] > QB'(33'h0_7FFF_FFFF)) begin
				q = 32'h7FFF_FFFF;
			end else begin
				q = quo_s[QB][31:0];
			end
		end
	end

endmodule

// ===== hw/rtl/matrix3_inverse_transpose.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse_transpose
// Inverse transpose of a 3x3 Q4.12 matrix by adjugate, Q16.16 results.
// ----------------------------------------------------------------------------
//  Channel    Dir   Contents
//  mat        in    nine Q4.12 entries, one matrix per request
//  res        out   nine Q16.16 entries and the singular flag
//  cfg        in    singular_limit write (cfg_we, cfg_wdata)
//
// One matrix enters every cycle unless a stalled result holds mat.ready low; each result
// passes through the cofactor pipeline and the 33 stages of the per-entry divider lanes.
// Reset clears the valid pipeline and the output valid and restores the default limit.
// A stalled result freezes the whole pipeline and holds mat.ready low.
// ----------------------------------------------------------------------------
module matrix3_inverse_transpose (
	input  logic                    clk,
	input  logic                    arst_n,
	mit_in_if.sink                  mat,
	mit_out_if.source               res,
	input  logic                    cfg_we,
	input  logic [mit_pkg::LimW-1:0] cfg_wdata
);

	localparam int unsigned LaneLat = mit_pkg::QBits + 1;
	localparam int unsigned NS      = mit_pkg::CofLat + LaneLat;

	logic            en;
	mit_pkg::lim_t   limit_q;
	logic            vld_q  [NS];
	logic            sing_q [LaneLat];
	mit_pkg::ent_t   m      [mit_pkg::NumEnt];
	mit_pkg::cof_t   cof    [mit_pkg::NumEnt];
	mit_pkg::det_t   det;
	mit_pkg::det_t   det_abs;
	mit_pkg::den_t   den;
	logic            sing;
	mit_pkg::res_t   lane_q [mit_pkg::NumEnt];
	mit_pkg::res_t   res_q  [mit_pkg::NumEnt];
	logic            res_sing_q;
	logic            res_valid_q;

	assign en        = !res_valid_q || res.ready;
	assign mat.ready = en;

	assign m[0] = mat.in_r0_c0;
	assign m[1] = mat.in_r0_c1;
	assign m[2] = mat.in_r0_c2;
	assign m[3] = mat.in_r1_c0;
	assign m[4] = mat.in_r1_c1;
	assign m[5] = mat.in_r1_c2;
	assign m[6] = mat.in_r2_c0;
	assign m[7] = mat.in_r2_c1;
	assign m[8] = mat.in_r2_c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= mit_pkg::LimitReset;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	mit_cofactor u_cofactor (
		.clk (clk),
		.en  (en),
		.m   (m),
		.cof (cof),
		.det (det)
	);

	assign det_abs = det[mit_pkg::DetW-1] ? -det : det;
	assign den     = det_abs[mit_pkg::DenW-1:0];
	assign sing    = (det == '0) || (den < mit_pkg::DenW'(limit_q));

	for (genvar k = 0; k < mit_pkg::NumEnt; k++) begin : g_lane
		mit_pkg::cof_t cof_abs;
		mit_pkg::num_t num;

		assign cof_abs = cof[k][mit_pkg::CofW-1] ? -cof[k] : cof[k];
		assign num     = {cof_abs[31:0], 28'd0};

		mit_div_lane u_lane (
			.clk (clk),
			.en  (en),
			.num (num),
			.den (den),
			.neg (cof[k][mit_pkg::CofW-1] ^ det[mit_pkg::DetW-1]),
			.q   (lane_q[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NS; i++) vld_q[i] <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= mat.valid;
			for (int i = 1; i < NS; i++) vld_q[i] <= vld_q[i-1];
			res_valid_q <= vld_q[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_q[0] <= sing;
			for (int i = 1; i < LaneLat; i++) sing_q[i] <= sing_q[i-1];
			res_sing_q <= sing_q[LaneLat-1];
			for (int i = 0; i < mit_pkg::NumEnt; i++) begin
				if (sing_q[LaneLat-1]) begin
					res_q[i] <= (i % 4 == 0) ? mit_pkg::Q16One : '0;
				end else begin
					res_q[i] <= lane_q[i];
				end
			end
		end
	end

	assign res.valid     = res_valid_q;
	assign res.singular  = res_sing_q;
	assign res.out_r0_c0 = res_q[0];
	assign res.out_r0_c1 = res_q[1];
	assign res.out_r0_c2 = res_q[2];
	assign res.out_r1_c0 = res_q[3];
	assign res.out_r1_c1 = res_q[4];
	assign res.out_r1_c2 = res_q[5];
	assign res.out_r2_c0 = res_q[6];
	assign res.out_r2_c1 = res_q[7];
	assign res.out_r2_c2 = res_q[8];

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res.ready |-> !mat.ready)
		else $error("input taken while result stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		mat.valid && mat.ready |=> vld_q[0])
		else $error("accepted request lost at pipeline entry");

	a_singular_ident: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_sing_q |-> res_q[0] == mit_pkg::Q16One && res_q[1] == '0
			&& res_q[4] == mit_pkg::Q16One && res_q[8] == mit_pkg::Q16One)
		else $error("singular result is not the identity");

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives 3x3 Q4.12 matrices into the inverse-transpose block, predicts each
// Q16.16 adjugate-over-determinant result and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;

	typedef struct {
		logic signed [31:0] ent [9];
		logic sing;
	} inv_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	mit_pkg::lim_t cfg_wdata;
	mit_in_if mat ();
	mit_out_if res ();

	matrix3_inverse_transpose dut (
		.clk(clk), .arst_n(arst_n), .mat(mat.sink), .res(res.source),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	localparam int Latency = 39;
	localparam longint CycleLimit = 400000;

	mit_pkg::lim_t model_limit;
	inv_t inverse_q[$];
	int mismatches;
	int results_seen;
	int singular_seen;
	longint cycles = 0;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] quot_sat(longint cof, longint det);
		longint unsigned num, den, q;
		bit neg;
		num = (cof < 0 ? -cof : cof) << 28;
		den = det < 0 ? -det : det;
		q = num / den;
		neg = (cof < 0) != (det < 0);
		if (neg) begin
			if (q > 64'd2147483648) q = 64'd2147483648;
			return 32'(-q);
		end
		if (q > 64'd2147483647) q = 64'd2147483647;
		return 32'(q);
	endfunction

	function automatic inv_t predict_inverse(logic signed [15:0] m [9]);
		longint v [9];
		longint c [9];
		longint det, mag;
		inv_t r;
		for (int k = 0; k < 9; k++) v[k] = m[k];
		c[0] = v[4]*v[8] - v[5]*v[7];
		c[1] = -(v[3]*v[8] - v[5]*v[6]);
		c[2] = v[3]*v[7] - v[4]*v[6];
		c[3] = -(v[1]*v[8] - v[2]*v[7]);
		c[4] = v[0]*v[8] - v[2]*v[6];
		c[5] = -(v[0]*v[7] - v[1]*v[6]);
		c[6] = v[1]*v[5] - v[2]*v[4];
		c[7] = -(v[0]*v[5] - v[2]*v[3]);
		c[8] = v[0]*v[4] - v[1]*v[3];
		det = v[0]*c[0] + v[1]*c[1] + v[2]*c[2];
		mag = det < 0 ? -det : det;
		if (det == 0 || mag < longint'(model_limit)) begin
			for (int k = 0; k < 9; k++) r.ent[k] = (k % 4 == 0) ? mit_pkg::Q16One : '0;
			r.sing = 1;
		end else begin
			for (int k = 0; k < 9; k++) r.ent[k] = quot_sat(c[k], det);
			r.sing = 0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic signed [31:0] got [9];
		inv_t want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.out_r0_c0, res.out_r0_c1, res.out_r0_c2, res.out_r1_c0,
				res.out_r1_c1, res.out_r1_c2, res.out_r2_c0, res.out_r2_c1, res.out_r2_c2};
			results_seen++;
			if (inverse_q.size() == 0) begin
				report_mismatch("unexpected result", results_seen, 0);
			end else begin
				want = inverse_q.pop_front();
				if (want.sing) singular_seen++;
				for (int k = 0; k < 9; k++)
					if (got[k] !== want.ent[k])
						report_mismatch($sformatf("entry %0d", k), got[k], want.ent[k]);
				if (res.singular !== want.sing)
					report_mismatch("singular", res.singular, want.sing);
			end
		end
	end

	always @(posedge clk) begin
		res.ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_matrix(logic signed [15:0] m [9]);
		while ($urandom_range(99) < send_idle_pct) begin
			mat.valid <= 0;
			@(posedge clk);
		end
		mat.valid <= 1;
		{mat.in_r0_c0, mat.in_r0_c1, mat.in_r0_c2, mat.in_r1_c0, mat.in_r1_c1,
			mat.in_r1_c2, mat.in_r2_c0, mat.in_r2_c1, mat.in_r2_c2} <=
			{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
		do @(posedge clk); while (!mat.ready);
		inverse_q = {inverse_q, predict_inverse(m)};
	endtask

	task automatic drain;
		mat.valid <= 0;
		while (inverse_q.size() != 0) @(posedge clk);
		repeat (Latency + 10) @(posedge clk);
	endtask

	task automatic write_limit(mit_pkg::lim_t v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		model_limit = v;
	endtask

	function automatic logic signed [15:0] rand_entry();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(16) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed;
		logic signed [15:0] m [9];
		m = '{16'sh1000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
		send_matrix(m);
		m = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff};
		send_matrix(m);
		m = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000};
		send_matrix(m);
		m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
		send_matrix(m);
		m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
		send_matrix(m);
		m = '{16'sh1000, 16'sh2000, 16'sh3000, 16'sh2000, 16'sh4000, 16'sh6000,
			1, 2, 3};
		send_matrix(m);
		m = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
			16'sh7fff, 16'sh7fff, 16'sh8000};
		send_matrix(m);
		m = '{16'sh8000, 16'sh7fff, 1, 16'shffff, 16'sh8000, 16'sh7fff,
			16'sh7fff, 0, 16'sh8000};
		send_matrix(m);
		m = '{16'sh0010, 0, 0, 0, 16'sh0010, 0, 0, 0, 16'sh0010};
		send_matrix(m);
		m = '{16'sh0100, 16'sh7fff, 0, 0, 16'sh0100, 16'sh8000, 16'sh7fff, 0, 16'sh0100};
		send_matrix(m);
		m = '{16'shf000, 0, 0, 0, 16'sh1000, 0, 0, 0, 16'sh1000};
		send_matrix(m);
	endtask

	task automatic test_random(int n);
		logic signed [15:0] m [9];
		for (int i = 0; i < n; i++) begin
			for (int k = 0; k < 9; k++) m[k] = rand_entry();
			if ($urandom_range(9) == 0) m[6:8] = m[0:2];
			send_matrix(m);
			if (i == n / 2) drain();
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		mismatches = 0;
		results_seen = 0;
		singular_seen = 0;
		model_limit = mit_pkg::LimitReset;
		mat.valid = 0;
		{mat.in_r0_c0, mat.in_r0_c1, mat.in_r0_c2, mat.in_r1_c0, mat.in_r1_c1,
			mat.in_r1_c2, mat.in_r2_c0, mat.in_r2_c1, mat.in_r2_c2} = '0;
		send_idle_pct = 34;
		recv_idle_pct = 87;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		test_directed();
		write_limit('0);
		test_directed();
		write_limit(40'hff_ffff_ffff);
		test_directed();
		test_random(50);
		write_limit(40'd1 << 36);
		test_random(250);
		send_idle_pct = 87;
		recv_idle_pct = 34;
		write_limit(mit_pkg::LimitReset);
		test_random(300);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_limit(mit_pkg::lim_t'({$urandom, $urandom} & 40'h00_ffff_ffff));
		test_random(350);
		drain();

		$display("Covered %0d results, %0d of them singular, over five limit settings.",
			results_seen, singular_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
